// ===== hw/rtl/dad_pkg.sv =====
// Shared types and constants for the detection anchor decoder.
package dad_pkg;

  // Upper bound on class scores per anchor
  localparam int unsigned MAX_CLASSES = 256;

  localparam int unsigned CoordW  = 16;  // Q12.4 coordinates
  localparam int unsigned ScoreW  = 16;  // Q0.16 scores
  localparam int unsigned ScaleW  = 24;  // Q8.16 reciprocal scale
  localparam int unsigned RawW    = 14;  // source image size
  localparam int unsigned PosW    = 13;  // clamped corner
  localparam int unsigned ClassW  = 8;
  localparam int unsigned TwiceW  = 19;  // 2*centre - size - 2*pad, signed
  localparam int unsigned CornerProdW = TwiceW + ScaleW + 1;
  localparam int unsigned SizeProdW   = CoordW + ScaleW;
  localparam int unsigned CornerShift = 21;
  localparam int unsigned SizeShift   = 20;

  localparam logic [ClassW-1:0] LastClass = ClassW'(MAX_CLASSES - 1);
  localparam logic [PosW-1:0]   PosMax    = {PosW{1'b1}};

  // APB register map
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_PAD_LEFT        = 3'd1,
    REG_PAD_TOP         = 3'd2,
    REG_INVERSE_SCALE   = 3'd3,
    REG_SOURCE_WIDTH    = 3'd4,
    REG_SOURCE_HEIGHT   = 3'd5
  } reg_idx_e;

  // Input item kinds
  typedef enum logic {
    KIND_GEOMETRY = 1'b0,
    KIND_SCORE    = 1'b1
  } kind_e;

  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic [ScoreW-1:0] class_score;
    logic              last_score;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]   left;
    logic [PosW-1:0]   top;
    logic [CoordW-1:0] out_width;
    logic [CoordW-1:0] out_height;
    logic [ClassW-1:0] class_id;
    logic [ScoreW-1:0] confidence;
  } out_item_t;

endpackage

// ===== hw/rtl/dad_in_if.sv =====
// Valid/ready channel carrying anchor input items.
interface dad_in_if
  import dad_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dad_out_if.sv =====
// Valid/ready channel carrying decoded box items.
interface dad_out_if
  import dad_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/detection_anchor_decode_core.sv =====
// Detection anchor decoder: argmax over class scores and letterbox rescale.
//
// Usage: each anchor is one geometry item (kind 0) on in_i followed by its
// class scores (kind 1), one per item, the final one flagged by last_score.
// When the best score of the anchor is strictly above the threshold, one box
// item leaves on out_o; otherwise the anchor yields nothing.
// Registers must be written over the APB port only while the block is idle;
// the block does not enforce this. pready is tied high; reads return the stored values.
// Throughput: one input item per cycle while in_i.ready is high. The argmax is
// updated as the item is accepted; a passing anchor then goes through an offset
// stage, a multiply stage (coordinate times reciprocal scale) and a clamp stage,
// each registered, and its box is valid on out_o once it sits in the clamp stage.
// Reset clears the held box, the argmax and the pipeline, and loads the
// register defaults (threshold 0.5, no pad, unit scale, 640x640 source).
// When out_o stalls, boxes queue in the three stages; in_i keeps accepting
// while any stage is free or the pipeline is moving, and drops ready only
// when all three hold a box and the output is not taken.
module detection_anchor_decode_core
  import dad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // Item channels
  dad_in_if.sink           in_i,
  dad_out_if.source        out_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ScoreW-1:0] thr_q;
  logic [CoordW-1:0] pad_left_q, pad_top_q;
  logic [ScaleW-1:0] inv_scale_q;
  logic [RawW-1:0]   src_w_q, src_h_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  // Write the addressed register; unknown addresses are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ScoreW'(32768);
      pad_left_q  <= '0;
      pad_top_q   <= '0;
      inv_scale_q <= ScaleW'(65536);
      src_w_q     <= RawW'(640);
      src_h_q     <= RawW'(640);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCORE_THRESHOLD: thr_q       <= pwdata[ScoreW-1:0];
        REG_PAD_LEFT:        pad_left_q  <= pwdata[CoordW-1:0];
        REG_PAD_TOP:         pad_top_q   <= pwdata[CoordW-1:0];
        REG_INVERSE_SCALE:   inv_scale_q <= pwdata[ScaleW-1:0];
        REG_SOURCE_WIDTH:    src_w_q     <= pwdata[RawW-1:0];
        REG_SOURCE_HEIGHT:   src_h_q     <= pwdata[RawW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_SCORE_THRESHOLD: prdata = DataW'(thr_q);
      REG_PAD_LEFT:        prdata = DataW'(pad_left_q);
      REG_PAD_TOP:         prdata = DataW'(pad_top_q);
      REG_INVERSE_SCALE:   prdata = DataW'(inv_scale_q);
      REG_SOURCE_WIDTH:    prdata = DataW'(src_w_q);
      REG_SOURCE_HEIGHT:   prdata = DataW'(src_h_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, s2_free, s1_free, in_acc;

  assign out_free   = !out_v_q || out_o.ready;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_i.ready = s1_free;
  assign in_acc     = in_i.valid && s1_free;

  // ---------------------------------------------------------------------
  // Held geometry and running argmax
  // ---------------------------------------------------------------------
  logic [CoordW-1:0] cx_q, cy_q, w_q, h_q;
  logic [ScoreW-1:0] best_q, best_d;
  logic [ClassW-1:0] best_cls_q, best_cls_d, cnt_q, cnt_d;
  logic              full_q, full_d;
  logic              emit;

  always_comb begin
    best_d     = best_q;
    best_cls_d = best_cls_q;
    cnt_d      = cnt_q;
    full_d     = full_q;
    emit       = 1'b0;
    if (kind_e'(in_i.data.kind) == KIND_GEOMETRY) begin
      best_d     = '0;
      best_cls_d = '0;
      cnt_d      = '0;
      full_d     = 1'b0;
    end else begin
      // Fold in the score unless the class limit is reached
      if (!full_q) begin
        if (in_i.data.class_score > best_q) begin
          best_d     = in_i.data.class_score;
          best_cls_d = cnt_q;
        end
        if (cnt_q == LastClass) full_d = 1'b1;
        else                    cnt_d  = cnt_q + 1'b1;
      end
      // Close the anchor on its last score
      if (in_i.data.last_score) begin
        emit       = best_d > thr_q;
        best_d     = '0;
        best_cls_d = '0;
        cnt_d      = '0;
        full_d     = 1'b0;
      end
    end
  end

  logic [ScoreW-1:0] fin_best;
  logic [ClassW-1:0] fin_cls;

  // Best score and class seen by the closing item, before the restart
  always_comb begin
    fin_best = best_q;
    fin_cls  = best_cls_q;
    if (!full_q && in_i.data.class_score > best_q) begin
      fin_best = in_i.data.class_score;
      fin_cls  = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q       <= '0;
      cy_q       <= '0;
      w_q        <= '0;
      h_q        <= '0;
      best_q     <= '0;
      best_cls_q <= '0;
      cnt_q      <= '0;
      full_q     <= 1'b0;
    end else if (in_acc) begin
      if (kind_e'(in_i.data.kind) == KIND_GEOMETRY) begin
        cx_q <= in_i.data.center_x;
        cy_q <= in_i.data.center_y;
        w_q  <= in_i.data.box_width;
        h_q  <= in_i.data.box_height;
      end
      best_q     <= best_d;
      best_cls_q <= best_cls_d;
      cnt_q      <= cnt_d;
      full_q     <= full_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: corner offsets in 1/32 pixel
  // ---------------------------------------------------------------------
  logic signed [TwiceW-1:0] twice_x, twice_y;
  logic signed [TwiceW-1:0] s1_tx_q, s1_ty_q;
  logic [CoordW-1:0]        s1_w_q, s1_h_q;
  logic [ClassW-1:0]        s1_cls_q;
  logic [ScoreW-1:0]        s1_score_q;

  assign twice_x = $signed({2'b00, cx_q, 1'b0}) - $signed({3'b000, w_q})
                 - $signed({2'b00, pad_left_q, 1'b0});
  assign twice_y = $signed({2'b00, cy_q, 1'b0}) - $signed({3'b000, h_q})
                 - $signed({2'b00, pad_top_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (s1_free) s1_v_q <= in_acc && emit;
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_acc && emit) begin
      s1_tx_q    <= twice_x;
      s1_ty_q    <= twice_y;
      s1_w_q     <= w_q;
      s1_h_q     <= h_q;
      s1_cls_q   <= fin_cls;
      s1_score_q <= fin_best;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: multiply by the reciprocal scale
  // ---------------------------------------------------------------------
  logic signed [CornerProdW-1:0] s2_px_q, s2_py_q;
  logic [SizeProdW-1:0]          s2_pw_q, s2_ph_q;
  logic [ClassW-1:0]             s2_cls_q;
  logic [ScoreW-1:0]             s2_score_q;
  logic signed [ScaleW:0]        inv_s;

  assign inv_s = $signed({1'b0, inv_scale_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (s2_free) s2_v_q <= s1_v_q;
  end

  // Widen both factors first so the full signed product is kept
  always_ff @(posedge clk_i) begin
    if (s2_free && s1_v_q) begin
      s2_px_q    <= CornerProdW'(s1_tx_q) * CornerProdW'(inv_s);
      s2_py_q    <= CornerProdW'(s1_ty_q) * CornerProdW'(inv_s);
      s2_pw_q    <= SizeProdW'(s1_w_q) * SizeProdW'(inv_scale_q);
      s2_ph_q    <= SizeProdW'(s1_h_q) * SizeProdW'(inv_scale_q);
      s2_cls_q   <= s1_cls_q;
      s2_score_q <= s1_score_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: truncate, clamp, saturate into the output register
  // ---------------------------------------------------------------------
  function automatic logic [PosW-1:0] clamp_corner(
    input logic signed [CornerProdW-1:0] prod,
    input logic [RawW-1:0]               raw
  );
    logic [CornerProdW-CornerShift-2:0] v;
    logic [PosW-1:0]                    lim;
    logic [RawW-1:0]                    raw_m1;
    begin
      v      = prod[CornerProdW-2:CornerShift];
      raw_m1 = raw - 1'b1;
      // Sources of 8192 pixels or more clamp at the widest corner
      if (raw[RawW-1]) lim = PosMax;
      else             lim = raw_m1[PosW-1:0];
      if (prod[CornerProdW-1] || prod == '0 || raw == '0) begin
        clamp_corner = '0;
      end else if (v > ($bits(v))'(lim)) begin
        clamp_corner = lim;
      end else begin
        clamp_corner = v[PosW-1:0];
      end
    end
  endfunction

  function automatic logic [CoordW-1:0] sat_size(input logic [SizeProdW-1:0] prod);
    begin
      if (|prod[SizeProdW-1:SizeShift+CoordW]) sat_size = {CoordW{1'b1}};
      else sat_size = prod[SizeShift+CoordW-1:SizeShift];
    end
  endfunction

  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (out_free) out_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_v_q) begin
      out_q.left       <= clamp_corner(s2_px_q, src_w_q);
      out_q.top        <= clamp_corner(s2_py_q, src_h_q);
      out_q.out_width  <= sat_size(s2_pw_q);
      out_q.out_height <= sat_size(s2_ph_q);
      out_q.class_id   <= s2_cls_q;
      out_q.confidence <= s2_score_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

// ===== bench/detection_anchor_decode_core_test.sv =====
// Self-checking bench for the anchor decoder: argmax, threshold and letterbox rescale.
`timescale 1ns / 100ps

module detection_anchor_decode_core_test;
  import dad_pkg::*;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t box;
  } row_t;

  typedef struct {
    logic [ScoreW-1:0] thr;
    logic [CoordW-1:0] pad_l;
    logic [CoordW-1:0] pad_t;
    logic [ScaleW-1:0] inv;
    logic [RawW-1:0]   src_w;
    logic [RawW-1:0]   src_h;
  } setting_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  dad_in_if  in_ch ();
  dad_out_if out_ch ();

  detection_anchor_decode_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // Register copies used for box prediction
  logic [ScoreW-1:0] cfg_thr;
  logic [CoordW-1:0] cfg_pad_l;
  logic [CoordW-1:0] cfg_pad_t;
  logic [ScaleW-1:0] cfg_inv;
  logic [RawW-1:0]   cfg_src_w;
  logic [RawW-1:0]   cfg_src_h;

  // Held geometry and running argmax
  logic [CoordW-1:0] held_cx;
  logic [CoordW-1:0] held_cy;
  logic [CoordW-1:0] held_w;
  logic [CoordW-1:0] held_h;
  logic [ScoreW-1:0] top_score;
  logic [ClassW-1:0] top_class;
  logic [ClassW-1:0] score_count;
  bit                count_full;

  out_item_t box_queue[$];
  row_t      plan[$];
  setting_t  settings[$];

  bit          row_typed;
  out_item_t   row_box;
  bit          steady_in;
  bit          steady_out;
  bit          hold_boxes;
  logic [15:0] last_drawn;
  int          errors;
  int          items_in;
  int          boxes_out;
  int          settings_used;

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Give up well beyond the slowest correct run
  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_argmax();
    top_score   = '0;
    top_class   = '0;
    score_count = '0;
    count_full  = 1'b0;
  endfunction

  // Corner in source pixels: (2*centre - size - 2*pad) * scale, 2^-21 units
  function automatic logic [PosW-1:0] corner_px(input logic [CoordW-1:0] centre,
                                                input logic [CoordW-1:0] size,
                                                input logic [CoordW-1:0] pad,
                                                input logic [RawW-1:0] raw);
    longint span;
    longint prod;
    longint lim;
    longint v;
    span = 2 * longint'(centre) - longint'(size) - 2 * longint'(pad);
    prod = span * longint'(cfg_inv);
    lim  = longint'(raw) - 1;
    if (lim > 8191) lim = 8191;
    if (prod <= 0) return '0;
    v = prod >>> 21;
    if (v > lim) v = lim;
    if (v < 0) v = 0;
    return PosW'(v);
  endfunction

  // Size in source pixels, 2^-20 units, saturated
  function automatic logic [CoordW-1:0] size_px(input logic [CoordW-1:0] size);
    longint v;
    v = (longint'(size) * longint'(cfg_inv)) >>> 20;
    if (v > 65535) v = 65535;
    return CoordW'(v);
  endfunction

  // Advance the decoder by one item; returns 1 when a box comes out
  function automatic bit decode_step(input in_item_t it, output out_item_t box);
    box = '0;
    if (it.kind == KIND_GEOMETRY) begin
      held_cx = it.center_x;
      held_cy = it.center_y;
      held_w  = it.box_width;
      held_h  = it.box_height;
      clear_argmax();
      return 1'b0;
    end
    if (!count_full) begin
      if (it.class_score > top_score) begin
        top_score = it.class_score;
        top_class = score_count;
      end
      if (score_count == LastClass) count_full = 1'b1;
      else score_count = score_count + 1'b1;
    end
    if (!it.last_score) return 1'b0;
    if (top_score > cfg_thr) begin
      box.left       = corner_px(held_cx, held_w, cfg_pad_l, cfg_src_w);
      box.top        = corner_px(held_cy, held_h, cfg_pad_t, cfg_src_h);
      box.out_width  = size_px(held_w);
      box.out_height = size_px(held_h);
      box.class_id   = top_class;
      box.confidence = top_score;
      clear_argmax();
      return 1'b1;
    end
    clear_argmax();
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic compare_box(input out_item_t want, input out_item_t got);
    if (want.left != got.left) report("left", want.left, got.left);
    if (want.top != got.top) report("top", want.top, got.top);
    if (want.out_width != got.out_width) report("out_width", want.out_width, got.out_width);
    if (want.out_height != got.out_height) report("out_height", want.out_height, got.out_height);
    if (want.class_id != got.class_id) report("class_id", want.class_id, got.class_id);
    if (want.confidence != got.confidence) report("confidence", want.confidence, got.confidence);
  endtask

  // Predict on every accepted item, compare every accepted box
  always @(posedge clk_i) begin : watch
    out_item_t box;
    out_item_t want;
    bit        made;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        made = decode_step(in_ch.data, box);
        if (row_typed) box_queue.insert(box_queue.size(), row_box);
        else if (made) box_queue.insert(box_queue.size(), box);
      end
      if (out_ch.valid && out_ch.ready) begin
        boxes_out++;
        if (box_queue.size() == 0) begin
          errors++;
          $display("%0t: box expected none, got %p", $time, out_ch.data);
        end else begin
          want = box_queue.pop_front();
          compare_box(want, out_ch.data);
        end
      end
    end
  end

  // ---------------------------------------------------------------- box side

  // Take boxes with a random stall per item, or one long hold on request
  initial begin : box_taker
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_boxes) begin
        hold_boxes = 1'b0;
        stall = 250;
      end else begin
        stall = steady_out ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t geo(input logic [15:0] cx, input logic [15:0] cy,
                                   input logic [15:0] w, input logic [15:0] h,
                                   input bit last);
    in_item_t it;
    it = '0;
    it.kind       = KIND_GEOMETRY;
    it.center_x   = cx;
    it.center_y   = cy;
    it.box_width  = w;
    it.box_height = h;
    it.last_score = last;
    return it;
  endfunction

  function automatic in_item_t sc(input logic [15:0] score, input bit last);
    in_item_t it;
    it = '0;
    it.kind        = KIND_SCORE;
    it.class_score = score;
    it.last_score  = last;
    return it;
  endfunction

  function automatic out_item_t boxv(input int l, input int t, input int w, input int h,
                                     input int c, input int s);
    out_item_t b;
    b.left       = PosW'(l);
    b.top        = PosW'(t);
    b.out_width  = CoordW'(w);
    b.out_height = CoordW'(h);
    b.class_id   = ClassW'(c);
    b.confidence = ScoreW'(s);
    return b;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t box);
    row_t r;
    r.it    = it;
    r.typed = typed;
    r.box   = box;
    plan.insert(plan.size(), r);
  endfunction

  // Append one register setting to the list
  function automatic void add_setting(input logic [ScoreW-1:0] thr,
                                      input logic [CoordW-1:0] pad_l,
                                      input logic [CoordW-1:0] pad_t,
                                      input logic [ScaleW-1:0] inv,
                                      input logic [RawW-1:0] src_w,
                                      input logic [RawW-1:0] src_h);
    setting_t s;
    s.thr   = thr;
    s.pad_l = pad_l;
    s.pad_t = pad_t;
    s.inv   = inv;
    s.src_w = src_w;
    s.src_h = src_h;
    settings.insert(settings.size(), s);
  endfunction

  // Offer one item after a random gap, hold it until accepted
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t box);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.data  = it;
    row_typed   = typed;
    row_box     = box;
    in_ch.valid = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_in++;
  endtask

  // Stop offering until every box is out and the pipeline has emptied
  task automatic settle();
    in_ch.valid = 1'b0;
    row_typed   = 1'b0;
    while (box_queue.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write one register over APB, then read it back
  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    logic [DataW-1:0] want;
    case (idx)
      REG_SCORE_THRESHOLD: begin cfg_thr = value[15:0]; want = DataW'(cfg_thr); end
      REG_PAD_LEFT:        begin cfg_pad_l = value[15:0]; want = DataW'(cfg_pad_l); end
      REG_PAD_TOP:         begin cfg_pad_t = value[15:0]; want = DataW'(cfg_pad_t); end
      REG_INVERSE_SCALE:   begin cfg_inv = value[23:0]; want = DataW'(cfg_inv); end
      REG_SOURCE_WIDTH:    begin cfg_src_w = value[13:0]; want = DataW'(cfg_src_w); end
      default:             begin cfg_src_h = value[13:0]; want = DataW'(cfg_src_h); end
    endcase
    paddr   = AddrW'(4 * int'(idx));
    pwdata  = want;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) report("register readback", want, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_SCORE_THRESHOLD, s.thr);
    write_reg(REG_PAD_LEFT, s.pad_l);
    write_reg(REG_PAD_TOP, s.pad_t);
    write_reg(REG_INVERSE_SCALE, s.inv);
    write_reg(REG_SOURCE_WIDTH, s.src_w);
    write_reg(REG_SOURCE_HEIGHT, s.src_h);
    settings_used++;
  endtask

  function automatic logic [15:0] coord_draw();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 16'h2800));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Scores biased towards the threshold, the extremes and ties
  function automatic logic [15:0] score_draw();
    logic [15:0] s;
    case ($urandom_range(0, 7))
      0:       s = 16'h0000;
      1:       s = 16'hFFFF;
      2, 3:    s = cfg_thr + 16'($urandom_range(0, 2)) - 16'd1;
      4:       s = last_drawn;
      default: s = 16'($urandom_range(0, 16'hFFFF));
    endcase
    last_drawn = s;
    return s;
  endfunction

  // One anchor: geometry then scores; now and then without geometry or last mark
  task automatic random_anchor();
    int n;
    int r;
    bit skip_geo;
    bit cut;
    skip_geo = ($urandom_range(0, 9) == 0);
    cut      = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 9);
    if (r < 7) n = $urandom_range(1, 6);
    else if (r < 9) n = $urandom_range(7, 40);
    else n = $urandom_range(41, 120);
    if (!skip_geo)
      send_item(geo(coord_draw(), coord_draw(), coord_draw(), coord_draw(),
                    $urandom_range(0, 1)), 1'b0, '0);
    for (int i = 0; i < n; i++)
      send_item(sc(score_draw(), (i == n - 1) && !cut), 1'b0, '0);
  endtask

  // Anchor past the class limit, with its peak at the given class index
  task automatic long_anchor(input int peak_at);
    send_item(geo(coord_draw(), coord_draw(), coord_draw(), coord_draw(), 1'b0), 1'b0, '0);
    for (int i = 0; i < 260; i++)
      send_item(sc((i == peak_at) ? 16'hFFFF : 16'($urandom_range(0, 16'h7FFF)), i == 259),
                1'b0, '0);
  endtask

  task automatic random_burst(input int target);
    logic [95:0] raw;
    int          stop_at;
    stop_at = items_in + target;
    while (items_in < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: raw items with every bit random
        repeat ($urandom_range(1, 3)) begin
          raw = {$urandom, $urandom, $urandom};
          send_item(raw[$bits(in_item_t)-1:0], 1'b0, '0);
        end
      end else begin
        random_anchor();
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : main
    setting_t s;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    row_typed     = 1'b0;
    row_box       = '0;
    steady_in     = 1'b0;
    steady_out    = 1'b0;
    hold_boxes    = 1'b0;
    last_drawn    = '0;
    errors        = 0;
    items_in      = 0;
    boxes_out     = 0;
    settings_used = 1;

    // Reset values of the predictor
    cfg_thr   = 16'd32768;
    cfg_pad_l = '0;
    cfg_pad_t = '0;
    cfg_inv   = 24'd65536;
    cfg_src_w = 14'd640;
    cfg_src_h = 14'd640;
    held_cx   = '0;
    held_cy   = '0;
    held_w    = '0;
    held_h    = '0;
    clear_argmax();

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows at reset settings: unit scale, no pad, 640x640, threshold 0.5
    // Scores before any geometry use the all-zero held box
    add_row(sc(16'hFFFF, 1), 1, boxv(0, 0, 0, 0, 0, 16'hFFFF));
    // Box at (100,80) px size 40x20; tie keeps the first class
    add_row(geo(1600, 1280, 640, 320, 0), 0, '0);
    add_row(sc(16'h1000, 0), 0, '0);
    add_row(sc(16'h9000, 0), 0, '0);
    add_row(sc(16'h9000, 0), 0, '0);
    add_row(sc(16'h2000, 1), 1, boxv(80, 70, 40, 20, 1, 16'h9000));
    // Scores after a last mark start a new anchor on the same box
    add_row(sc(16'hA000, 0), 0, '0);
    add_row(sc(16'hB000, 1), 1, boxv(80, 70, 40, 20, 1, 16'hB000));
    // Score equal to the threshold does not pass
    add_row(sc(16'h8000, 1), 0, '0);
    // Single class gives class 0
    add_row(sc(16'h8001, 1), 1, boxv(80, 70, 40, 20, 0, 16'h8001));
    // All scores zero
    add_row(sc(16'h0000, 0), 0, '0);
    add_row(sc(16'h0000, 1), 0, '0);
    // Last mark on geometry is ignored; corners clamp to the source edge
    add_row(geo(16'hFFFF, 16'hFFFF, 0, 0, 1), 0, '0);
    add_row(sc(16'hFFFF, 1), 1, boxv(639, 639, 0, 0, 0, 16'hFFFF));
    // Geometry in the middle of an anchor drops the partial argmax
    add_row(geo(0, 0, 16'hFFFF, 16'hFFFF, 0), 0, '0);
    add_row(sc(16'hF000, 0), 0, '0);
    add_row(geo(1600, 1280, 640, 320, 0), 0, '0);
    add_row(sc(16'h7000, 0), 0, '0);
    add_row(sc(16'h9000, 1), 1, boxv(80, 70, 40, 20, 1, 16'h9000));
    // Negative corner goes to 0, widest size
    add_row(geo(0, 0, 16'hFFFF, 16'hFFFF, 0), 0, '0);
    add_row(sc(16'hFFFF, 1), 1, boxv(0, 0, 4095, 4095, 0, 16'hFFFF));

    foreach (plan[i]) send_item(plan[i].it, plan[i].typed, plan[i].box);
    settle();
    random_burst(150);
    settle();

    // Fixed settings with the extremes, then random ones
    add_setting(16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 14'd8192, 14'd1);
    add_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h000000, 14'd1, 14'd8192);
    add_setting(16'h4000, 16'h0000, 16'h08C0, 24'h030000, 14'd1920, 14'd1080);
    add_setting(16'h0000, 16'hFFFF, 16'h0000, 24'h020000, 14'd0, 14'd16383);
    repeat (2) begin
      s.thr   = 16'($urandom_range(0, 16'hFFFF));
      s.pad_l = 16'($urandom_range(0, 16'h1000));
      s.pad_t = 16'($urandom_range(0, 16'h1000));
      s.inv   = 24'($urandom_range(0, 24'hFFFFFF));
      s.src_w = 14'($urandom_range(1, 8192));
      s.src_h = 14'($urandom_range(1, 8192));
      settings.insert(settings.size(), s);
    end

    foreach (settings[k]) begin
      apply_setting(settings[k]);
      steady_in  = ($urandom_range(0, 2) == 0);
      steady_out = ($urandom_range(0, 2) == 0);
      if (k == 0) begin
        // threshold 0: both long anchors give boxes
        long_anchor(255);
        long_anchor(257);
      end
      if (k == 2) begin
        // stall the box side while items keep coming, to fill the pipeline
        steady_in  = 1'b1;
        hold_boxes = 1'b1;
      end
      random_burst(150);
      settle();
    end

    $display("Covered %0d input items and %0d decoded boxes over %0d register settings,",
             items_in, boxes_out, settings_used);
    $display("with long output stalls, anchors past the class limit and malformed streams.");
    if (errors == 0 && box_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
